FILE: hw/rtl/wqvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wqvt_pkg;

    localparam int SLOT_W     = 5;
    localparam int WEIGHT_W   = 32;
    localparam int SUM_W      = 40;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_THRESHOLD     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_TOTAL_WEIGHT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PENDING_ENABLED      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PENDING_THRESHOLD    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PENDING_TOTAL_WEIGHT = 3'd4;

    typedef enum logic [2:0] {
        MODE_UNRESTRICTED  = 3'd0,
        MODE_RESTRICTED    = 3'd1,
        MODE_WEAK_ACHIEVED = 3'd2,
        MODE_WEAK_FINAL    = 3'd3,
        MODE_STRONG        = 3'd4
    } quorum_mode_t;

    typedef enum logic [1:0] {
        PRIOR_NONE   = 2'd0,
        PRIOR_WEAK   = 2'd1,
        PRIOR_STRONG = 2'd2
    } prior_t;

    typedef enum logic [1:0] {
        VERDICT_ACCEPTED    = 2'd0,
        VERDICT_DUPLICATE   = 2'd1,
        VERDICT_CONFLICTING = 2'd2,
        VERDICT_UNKNOWN     = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [SUM_W-1:0] threshold;
        logic [SUM_W-1:0] total_weight;
    } set_cfg_t;

    typedef struct packed {
        logic                present;
        logic                record;
        logic                is_strong;
        logic [SLOT_W-1:0]   slot;
        logic [WEIGHT_W-1:0] weight;
    } tally_req_t;

    typedef struct packed {
        logic         member;
        prior_t       prior;
        quorum_mode_t mode_next;
    } tally_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wqvt_tally.sv
`timescale 1ns / 1ps
`default_nettype none

module wqvt_tally
    import wqvt_pkg::*;
#(
    parameter int MAX_FINALIZERS = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire set_cfg_t   cfg,
    input  wire tally_req_t req,
    output tally_sts_t      sts
);

    logic [MAX_FINALIZERS-1:0] strong_map_reg, strong_map_next;
    logic [MAX_FINALIZERS-1:0] weak_map_reg, weak_map_next;
    logic [SUM_W-1:0]          strong_sum_reg, strong_sum_next;
    logic [SUM_W-1:0]          weak_sum_reg, weak_sum_next;
    logic [SUM_W-1:0]          both_sum_reg, both_sum_next;
    quorum_mode_t              mode_reg, mode_next;

    logic [MAX_FINALIZERS-1:0] sel;
    logic                      member;
    logic                      hit_strong;
    logic                      hit_weak;
    logic [SUM_W-1:0]          limit;
    logic [SUM_W-1:0]          upd_sum;
    logic [SUM_W-1:0]          both_new;
    quorum_mode_t              weak_mode;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [WEIGHT_W-1:0] b);
        logic [SUM_W:0] wide;
        wide = {1'b0, a} + (SUM_W + 1)'(b);
        return wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
    endfunction

    always_comb begin
        for (int i = 0; i < MAX_FINALIZERS; i++) begin
            sel[i] = (int'(req.slot) == i);
        end
        member     = req.present && (int'(req.slot) < MAX_FINALIZERS);
        hit_strong = |(strong_map_reg & sel);
        hit_weak   = |(weak_map_reg & sel);

        if (!member) begin
            sts.prior = PRIOR_NONE;
        end else if (hit_strong) begin
            sts.prior = PRIOR_STRONG;
        end else if (hit_weak) begin
            sts.prior = PRIOR_WEAK;
        end else begin
            sts.prior = PRIOR_NONE;
        end
        sts.member = member;

        limit    = (cfg.total_weight >= cfg.threshold) ?
                   (cfg.total_weight - cfg.threshold) : '0;
        upd_sum  = sat_add(req.is_strong ? strong_sum_reg : weak_sum_reg, req.weight);
        both_new = sat_add(both_sum_reg, req.weight);

        strong_map_next = strong_map_reg;
        weak_map_next   = weak_map_reg;
        strong_sum_next = strong_sum_reg;
        weak_sum_next   = weak_sum_reg;
        both_sum_next   = both_sum_reg;
        mode_next       = mode_reg;
        weak_mode       = mode_reg;

        if (req.record && member) begin
            both_sum_next = both_new;
            if (req.is_strong) begin
                strong_map_next = strong_map_reg | sel;
                strong_sum_next = upd_sum;
                case (mode_reg)
                    MODE_UNRESTRICTED, MODE_RESTRICTED: begin
                        if (upd_sum >= cfg.threshold) begin
                            mode_next = MODE_STRONG;
                        end else if (both_new >= cfg.threshold) begin
                            mode_next = (mode_reg == MODE_RESTRICTED) ?
                                        MODE_WEAK_FINAL : MODE_WEAK_ACHIEVED;
                        end
                    end
                    MODE_WEAK_ACHIEVED: begin
                        if (upd_sum >= cfg.threshold) begin
                            mode_next = MODE_STRONG;
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                weak_map_next = weak_map_reg | sel;
                weak_sum_next = upd_sum;
                case (mode_reg)
                    MODE_UNRESTRICTED, MODE_RESTRICTED: begin
                        if (both_new >= cfg.threshold) begin
                            weak_mode = MODE_WEAK_ACHIEVED;
                        end
                        if (upd_sum > limit) begin
                            if (weak_mode == MODE_WEAK_ACHIEVED) begin
                                weak_mode = MODE_WEAK_FINAL;
                            end else if (weak_mode == MODE_UNRESTRICTED) begin
                                weak_mode = MODE_RESTRICTED;
                            end
                        end
                        mode_next = weak_mode;
                    end
                    MODE_WEAK_ACHIEVED: begin
                        if (upd_sum > limit) begin
                            mode_next = MODE_WEAK_FINAL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        sts.mode_next = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strong_map_reg <= '0;
            weak_map_reg   <= '0;
            strong_sum_reg <= '0;
            weak_sum_reg   <= '0;
            both_sum_reg   <= '0;
            mode_reg       <= MODE_UNRESTRICTED;
        end else begin
            strong_map_reg <= strong_map_next;
            weak_map_reg   <= weak_map_next;
            strong_sum_reg <= strong_sum_next;
            weak_sum_reg   <= weak_sum_next;
            both_sum_reg   <= both_sum_next;
            mode_reg       <= mode_next;
        end
    end

    ap_mode_terminal: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_STRONG || mode_reg == MODE_WEAK_FINAL) |=> $stable(mode_reg))
        else $error("quorum mode left a terminal state");

    ap_maps_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (strong_map_reg & weak_map_reg) == '0)
        else $error("slot holds both a strong and a weak vote");

endmodule

`default_nettype wire

FILE: hw/rtl/weighted_quorum_vote_tally.sv
// Weighted quorum vote tally. One vote transaction can be taken every cycle;
// each gives exactly one result, which shows on the result port once it has
// moved from the input register into the result register. The per-set
// tallies (slot maps, weight sums, quorum state) update at the same edge as
// the result register, so the next vote already sees them. The input side
// keeps taking votes while a result waits, until both registers are full.
// Configuration registers must be written by the user only while the block is
// idle, which the block does not enforce; writes apply to the votes that follow.
`timescale 1ns / 1ps
`default_nettype none

module weighted_quorum_vote_tally
    import wqvt_pkg::*;
#(
    parameter int MAX_FINALIZERS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_vote_strength,
    input  wire logic                  s_in_active,
    input  wire logic [SLOT_W-1:0]     s_active_slot,
    input  wire logic [WEIGHT_W-1:0]   s_active_weight,
    input  wire logic                  s_in_pending,
    input  wire logic [SLOT_W-1:0]     s_pending_slot,
    input  wire logic [WEIGHT_W-1:0]   s_pending_weight,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_verdict,
    output logic [2:0]                 m_active_quorum_state,
    output logic [2:0]                 m_pending_quorum_state,
    output logic                       m_certificate_ready,
    output logic                       m_certificate_strong
);

    set_cfg_t              active_cfg_reg;
    set_cfg_t              pending_cfg_reg;
    logic                  pending_enabled_reg;

    logic                  in_valid_reg;
    logic                  strength_reg;
    logic                  in_active_reg;
    logic [SLOT_W-1:0]     active_slot_reg;
    logic [WEIGHT_W-1:0]   active_weight_reg;
    logic                  in_pending_reg;
    logic [SLOT_W-1:0]     pending_slot_reg;
    logic [WEIGHT_W-1:0]   pending_weight_reg;

    logic                  m_valid_reg;
    verdict_t              m_verdict_reg;
    quorum_mode_t          m_active_mode_reg;
    quorum_mode_t          m_pending_mode_reg;
    logic                  m_cert_ready_reg;
    logic                  m_cert_strong_reg;

    logic                  advance;
    tally_req_t            active_req;
    tally_req_t            pending_req;
    tally_sts_t            active_sts;
    tally_sts_t            pending_sts;
    verdict_t              verdict;
    prior_t                kind;
    prior_t                existing;
    quorum_mode_t          pending_mode;
    logic                  cert_ready;
    logic                  cert_strong;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_cfg_reg      <= '0;
            pending_cfg_reg     <= '0;
            pending_enabled_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_ACTIVE_THRESHOLD:     active_cfg_reg.threshold     <= cfg_wdata;
                CFG_ACTIVE_TOTAL_WEIGHT:  active_cfg_reg.total_weight  <= cfg_wdata;
                CFG_PENDING_ENABLED:      pending_enabled_reg          <= cfg_wdata[0];
                CFG_PENDING_THRESHOLD:    pending_cfg_reg.threshold    <= cfg_wdata;
                CFG_PENDING_TOTAL_WEIGHT: pending_cfg_reg.total_weight <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            strength_reg       <= s_vote_strength;
            in_active_reg      <= s_in_active;
            active_slot_reg    <= s_active_slot;
            active_weight_reg  <= s_active_weight;
            in_pending_reg     <= s_in_pending;
            pending_slot_reg   <= s_pending_slot;
            pending_weight_reg <= s_pending_weight;
        end
    end

    always_comb begin
        active_req.present    = in_active_reg;
        active_req.is_strong  = strength_reg;
        active_req.slot       = active_slot_reg;
        active_req.weight     = active_weight_reg;
        pending_req.present   = in_pending_reg && pending_enabled_reg;
        pending_req.is_strong = strength_reg;
        pending_req.slot      = pending_slot_reg;
        pending_req.weight    = pending_weight_reg;

        kind     = strength_reg ? PRIOR_STRONG : PRIOR_WEAK;
        existing = (active_sts.prior != PRIOR_NONE) ? active_sts.prior : pending_sts.prior;

        if (!active_sts.member && !pending_sts.member) begin
            verdict = VERDICT_UNKNOWN;
        end else if (active_sts.prior != PRIOR_NONE && pending_sts.prior != PRIOR_NONE &&
                     active_sts.prior != pending_sts.prior) begin
            verdict = VERDICT_CONFLICTING;
        end else if (existing == PRIOR_NONE) begin
            verdict = VERDICT_ACCEPTED;
        end else if (existing == kind) begin
            verdict = VERDICT_DUPLICATE;
        end else begin
            verdict = VERDICT_CONFLICTING;
        end

        active_req.record  = advance && (verdict == VERDICT_ACCEPTED);
        pending_req.record = advance && (verdict == VERDICT_ACCEPTED);

        pending_mode = pending_enabled_reg ? pending_sts.mode_next : MODE_UNRESTRICTED;
        cert_ready   = (active_sts.mode_next inside {MODE_WEAK_ACHIEVED, MODE_WEAK_FINAL,
                                                     MODE_STRONG}) &&
                       (!pending_enabled_reg ||
                        (pending_mode inside {MODE_WEAK_ACHIEVED, MODE_WEAK_FINAL,
                                              MODE_STRONG}));
        cert_strong  = cert_ready && (active_sts.mode_next == MODE_STRONG) &&
                       (!pending_enabled_reg || pending_mode == MODE_STRONG);
    end

    wqvt_tally #(
        .MAX_FINALIZERS(MAX_FINALIZERS)
    ) u_active_tally (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (active_cfg_reg),
        .req     (active_req),
        .sts     (active_sts)
    );

    wqvt_tally #(
        .MAX_FINALIZERS(MAX_FINALIZERS)
    ) u_pending_tally (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (pending_cfg_reg),
        .req     (pending_req),
        .sts     (pending_sts)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance) begin
            m_verdict_reg      <= verdict;
            m_active_mode_reg  <= active_sts.mode_next;
            m_pending_mode_reg <= pending_mode;
            m_cert_ready_reg   <= cert_ready;
            m_cert_strong_reg  <= cert_strong;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_verdict              = m_verdict_reg;
    assign m_active_quorum_state  = m_active_mode_reg;
    assign m_pending_quorum_state = m_pending_mode_reg;
    assign m_certificate_ready    = m_cert_ready_reg;
    assign m_certificate_strong   = m_cert_strong_reg;

    ap_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("processed vote produced no result");

    ap_strong_implies_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!m_cert_strong_reg || m_cert_ready_reg))
        else $error("strong certificate reported without ready");

    ap_pending_off_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !pending_enabled_reg) |-> (m_pending_mode_reg == MODE_UNRESTRICTED))
        else $error("pending state shown while pending set disabled");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import wqvt_pkg::*;

    localparam int MAX_SLOTS      = 32;
    localparam int HOLD_CYCLES    = 64;
    localparam int PHASES         = 8;
    localparam int VOTES_PER_PASS = 80;

    typedef struct packed {
        logic                strength;
        logic                in_active;
        logic [SLOT_W-1:0]   a_slot;
        logic [WEIGHT_W-1:0] a_weight;
        logic                in_pending;
        logic [SLOT_W-1:0]   p_slot;
        logic [WEIGHT_W-1:0] p_weight;
    } vote_t;

    typedef struct packed {
        verdict_t     verdict;
        quorum_mode_t a_mode;
        quorum_mode_t p_mode;
        logic         cert_ready;
        logic         cert_strong;
    } outcome_t;

    typedef struct packed {
        logic [MAX_SLOTS-1:0] strong_map;
        logic [MAX_SLOTS-1:0] weak_map;
        logic [SUM_W-1:0]     strong_sum;
        logic [SUM_W-1:0]     weak_sum;
        quorum_mode_t         mode;
    } set_tally_t;

    class quorum_tally;
        set_tally_t       active_set;
        set_tally_t       pending_set;
        logic [SUM_W-1:0] a_thr;
        logic [SUM_W-1:0] a_tot;
        logic [SUM_W-1:0] p_thr;
        logic [SUM_W-1:0] p_tot;
        logic             p_on;
        outcome_t         expected_outcomes[$];
        int               mismatches;
        int               checked;
        int               verdict_count[4];

        function new();
            active_set  = '0;
            pending_set = '0;
            a_thr = '0;
            a_tot = '0;
            p_thr = '0;
            p_tot = '0;
            p_on  = 1'b0;
            mismatches = 0;
            checked = 0;
            foreach (verdict_count[i]) verdict_count[i] = 0;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_ACTIVE_THRESHOLD:     a_thr = value;
                CFG_ACTIVE_TOTAL_WEIGHT:  a_tot = value;
                CFG_PENDING_ENABLED:      p_on  = value[0];
                CFG_PENDING_THRESHOLD:    p_thr = value;
                CFG_PENDING_TOTAL_WEIGHT: p_tot = value;
                default: ;
            endcase
        endfunction

        function prior_t prior_of(set_tally_t t, logic [SLOT_W-1:0] slot);
            if (t.strong_map[slot]) return PRIOR_STRONG;
            if (t.weak_map[slot]) return PRIOR_WEAK;
            return PRIOR_NONE;
        endfunction

        function logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
            logic [SUM_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
        endfunction

        function set_tally_t tally_vote(set_tally_t t, logic [SLOT_W-1:0] slot,
                                        logic [WEIGHT_W-1:0] weight, logic strength,
                                        logic [SUM_W-1:0] thr, logic [SUM_W-1:0] tot);
            logic [SUM_W-1:0] limit;
            logic [SUM_W-1:0] both;
            logic [SUM_W-1:0] wide_weight;
            limit = (tot >= thr) ? tot - thr : '0;
            wide_weight = SUM_W'(weight);
            if (strength) begin
                t.strong_map[slot] = 1'b1;
                t.strong_sum = add_sat(t.strong_sum, wide_weight);
                both = add_sat(t.strong_sum, t.weak_sum);
                if (t.mode == MODE_UNRESTRICTED || t.mode == MODE_RESTRICTED) begin
                    if (t.strong_sum >= thr)
                        t.mode = MODE_STRONG;
                    else if (both >= thr && t.mode == MODE_RESTRICTED)
                        t.mode = MODE_WEAK_FINAL;
                    else if (both >= thr)
                        t.mode = MODE_WEAK_ACHIEVED;
                end else if (t.mode == MODE_WEAK_ACHIEVED && t.strong_sum >= thr) begin
                    t.mode = MODE_STRONG;
                end
            end else begin
                t.weak_map[slot] = 1'b1;
                t.weak_sum = add_sat(t.weak_sum, wide_weight);
                both = add_sat(t.strong_sum, t.weak_sum);
                if (t.mode == MODE_UNRESTRICTED || t.mode == MODE_RESTRICTED) begin
                    if (both >= thr)
                        t.mode = MODE_WEAK_ACHIEVED;
                    if (t.weak_sum > limit) begin
                        if (t.mode == MODE_WEAK_ACHIEVED)
                            t.mode = MODE_WEAK_FINAL;
                        else if (t.mode == MODE_UNRESTRICTED)
                            t.mode = MODE_RESTRICTED;
                    end
                end else if (t.mode == MODE_WEAK_ACHIEVED && t.weak_sum > limit) begin
                    t.mode = MODE_WEAK_FINAL;
                end
            end
            return t;
        endfunction

        function void note_vote(vote_t v);
            logic     a_mem;
            logic     p_mem;
            prior_t   kind;
            prior_t   a_prior;
            prior_t   p_prior;
            logic     a_ok;
            logic     p_ok;
            outcome_t o;
            a_mem = v.in_active && (v.a_slot < MAX_SLOTS);
            p_mem = p_on && v.in_pending && (v.p_slot < MAX_SLOTS);
            kind  = v.strength ? PRIOR_STRONG : PRIOR_WEAK;
            if (!a_mem && !p_mem) begin
                o.verdict = VERDICT_UNKNOWN;
            end else begin
                a_prior = a_mem ? prior_of(active_set, v.a_slot) : PRIOR_NONE;
                p_prior = p_mem ? prior_of(pending_set, v.p_slot) : PRIOR_NONE;
                if (a_prior != PRIOR_NONE && p_prior != PRIOR_NONE && a_prior != p_prior)
                    o.verdict = VERDICT_CONFLICTING;
                else begin
                    if (a_prior == PRIOR_NONE)
                        a_prior = p_prior;
                    if (a_prior == PRIOR_NONE)
                        o.verdict = VERDICT_ACCEPTED;
                    else if (a_prior == kind)
                        o.verdict = VERDICT_DUPLICATE;
                    else
                        o.verdict = VERDICT_CONFLICTING;
                end
            end
            if (o.verdict == VERDICT_ACCEPTED) begin
                if (a_mem)
                    active_set = tally_vote(active_set, v.a_slot, v.a_weight, v.strength,
                                            a_thr, a_tot);
                if (p_mem)
                    pending_set = tally_vote(pending_set, v.p_slot, v.p_weight, v.strength,
                                             p_thr, p_tot);
            end
            o.a_mode = active_set.mode;
            o.p_mode = p_on ? pending_set.mode : MODE_UNRESTRICTED;
            a_ok = (o.a_mode == MODE_WEAK_ACHIEVED || o.a_mode == MODE_WEAK_FINAL ||
                    o.a_mode == MODE_STRONG);
            p_ok = (o.p_mode == MODE_WEAK_ACHIEVED || o.p_mode == MODE_WEAK_FINAL ||
                    o.p_mode == MODE_STRONG);
            o.cert_ready  = a_ok && (!p_on || p_ok);
            o.cert_strong = o.cert_ready && o.a_mode == MODE_STRONG &&
                            (!p_on || o.p_mode == MODE_STRONG);
            verdict_count[o.verdict]++;
            expected_outcomes.push_back(o);
        endfunction

        function void check_outcome(logic [1:0] verdict, logic [2:0] a_mode, logic [2:0] p_mode,
                                    logic cert_ready, logic cert_strong);
            outcome_t e;
            checked++;
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no vote outstanding: verdict %0d a %0d p %0d %b%b",
                             $time, verdict, a_mode, p_mode, cert_ready, cert_strong);
                return;
            end
            e = expected_outcomes.pop_front();
            if (verdict !== e.verdict || a_mode !== e.a_mode || p_mode !== e.p_mode ||
                cert_ready !== e.cert_ready || cert_strong !== e.cert_strong) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: tally mismatch: expected verdict %0d a %0d p %0d ready %b ",
                              "strong %b, got verdict %0d a %0d p %0d ready %b strong %b"},
                             $time, e.verdict, e.a_mode, e.p_mode, e.cert_ready,
                             e.cert_strong, verdict, a_mode, p_mode, cert_ready, cert_strong);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_vote_strength;
    logic                  s_in_active;
    logic [SLOT_W-1:0]     s_active_slot;
    logic [WEIGHT_W-1:0]   s_active_weight;
    logic                  s_in_pending;
    logic [SLOT_W-1:0]     s_pending_slot;
    logic [WEIGHT_W-1:0]   s_pending_weight;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_verdict;
    logic [2:0]            m_active_quorum_state;
    logic [2:0]            m_pending_quorum_state;
    logic                  m_certificate_ready;
    logic                  m_certificate_strong;

    logic        no_idle = 1'b0;
    logic        hold_request = 1'b0;
    int          cfg_writes = 0;
    int          votes_sent = 0;
    quorum_tally tally = new();

    weighted_quorum_vote_tally #(.MAX_FINALIZERS(MAX_SLOTS)) u_top (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_we                 (cfg_we),
        .cfg_addr               (cfg_addr),
        .cfg_wdata              (cfg_wdata),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_vote_strength        (s_vote_strength),
        .s_in_active            (s_in_active),
        .s_active_slot          (s_active_slot),
        .s_active_weight        (s_active_weight),
        .s_in_pending           (s_in_pending),
        .s_pending_slot         (s_pending_slot),
        .s_pending_weight       (s_pending_weight),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_verdict              (m_verdict),
        .m_active_quorum_state  (m_active_quorum_state),
        .m_pending_quorum_state (m_pending_quorum_state),
        .m_certificate_ready    (m_certificate_ready),
        .m_certificate_strong   (m_certificate_strong)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random back-pressure, plus one long hold on request
    initial begin
        int held;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready = 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge aclk);
                hold_request = 1'b0;
            end
            m_ready = no_idle || ($urandom_range(0, 99) >= 32);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tally.check_outcome(m_verdict, m_active_quorum_state, m_pending_quorum_state,
                                m_certificate_ready, m_certificate_strong);
    end

    function automatic vote_t make_vote(logic strength, logic in_a, logic [SLOT_W-1:0] a_slot,
                                        logic [WEIGHT_W-1:0] a_weight, logic in_p,
                                        logic [SLOT_W-1:0] p_slot,
                                        logic [WEIGHT_W-1:0] p_weight);
        vote_t v;
        v.strength   = strength;
        v.in_active  = in_a;
        v.a_slot     = a_slot;
        v.a_weight   = a_weight;
        v.in_pending = in_p;
        v.p_slot     = p_slot;
        v.p_weight   = p_weight;
        return v;
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [SUM_W-1:0] pick_level();
        logic [SUM_W-1:0] lvl;
        lvl = SUM_W'($urandom_range(0, 40));
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return lvl << 31;
        endcase
    endfunction

    // fresh slots open up a few at a time so that later passes still record votes
    function automatic vote_t random_vote(int window);
        vote_t v;
        v.strength   = 1'($urandom_range(0, 1));
        v.in_active  = ($urandom_range(0, 9) != 0);
        v.in_pending = ($urandom_range(0, 4) != 0);
        v.a_slot     = SLOT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(0, window));
        v.p_slot     = SLOT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(0, window));
        v.a_weight   = pick_weight();
        v.p_weight   = pick_weight();
        return v;
    endfunction

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        tally.set_register(idx, value);
        cfg_writes++;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic send_vote(vote_t v);
        while (!no_idle && $urandom_range(0, 99) < 32) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_vote_strength  = v.strength;
        s_in_active      = v.in_active;
        s_active_slot    = v.a_slot;
        s_active_weight  = v.a_weight;
        s_in_pending     = v.in_pending;
        s_pending_slot   = v.p_slot;
        s_pending_weight = v.p_weight;
        do @(posedge aclk); while (!s_ready);
        tally.note_vote(v);
        votes_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (tally.expected_outcomes.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        int phase;
        int n;
        int window;
        aresetn          = 1'b0;
        cfg_we           = 1'b0;
        cfg_addr         = '0;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_vote_strength  = 1'b0;
        s_in_active      = 1'b0;
        s_active_slot    = '0;
        s_active_weight  = '0;
        s_in_pending     = 1'b0;
        s_pending_slot   = '0;
        s_pending_weight = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // threshold above total on the active set, full-scale pending set
        write_reg(CFG_ACTIVE_THRESHOLD, '1);
        write_reg(CFG_ACTIVE_TOTAL_WEIGHT, '0);
        write_reg(CFG_PENDING_ENABLED, 1);
        write_reg(CFG_PENDING_THRESHOLD, '1);
        write_reg(CFG_PENDING_TOTAL_WEIGHT, '1);
        send_vote(make_vote(1, 0, 31, '1, 0, 31, '1));
        send_vote(make_vote(0, 1, 0, '0, 1, 0, '0));
        send_vote(make_vote(0, 1, 1, '1, 0, 1, '1));
        send_vote(make_vote(0, 1, 1, '1, 0, 1, '1));
        send_vote(make_vote(1, 1, 1, '1, 0, 1, '1));
        send_vote(make_vote(0, 0, 3, '1, 1, 3, 5));
        send_vote(make_vote(1, 0, 4, 7, 1, 4, '1));
        send_vote(make_vote(0, 1, 1, 9, 1, 4, 9));
        send_vote(make_vote(1, 1, 6, 9, 1, 4, 9));
        send_vote(make_vote(0, 1, 6, 9, 1, 4, 9));
        send_vote(make_vote(1, 1, 7, 1, 1, 8, 1));
        drain();

        // lower the bar; zero threshold on the pending set
        write_reg(CFG_ACTIVE_THRESHOLD, 40'h01_0000_0000);
        write_reg(CFG_ACTIVE_TOTAL_WEIGHT, 40'h02_0000_0000);
        write_reg(CFG_PENDING_THRESHOLD, '0);
        write_reg(CFG_PENDING_TOTAL_WEIGHT, '0);
        send_vote(make_vote(1, 1, 9, 32'h10, 1, 10, 32'h10));
        drain();
        write_reg(CFG_PENDING_ENABLED, 0);
        send_vote(make_vote(0, 0, 11, 1, 1, 11, 1));
        send_vote(make_vote(0, 1, 2, 32'h8000_0000, 1, 12, 3));
        drain();
        write_reg(CFG_PENDING_ENABLED, 1);
        send_vote(make_vote(0, 0, 12, 1, 1, 12, 32'h5555_5555));

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            write_reg(CFG_ACTIVE_THRESHOLD, pick_level());
            write_reg(CFG_ACTIVE_TOTAL_WEIGHT, pick_level());
            write_reg(CFG_PENDING_ENABLED, CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(CFG_PENDING_THRESHOLD, pick_level());
            write_reg(CFG_PENDING_TOTAL_WEIGHT, pick_level());
            window = (7 + 4 * phase > 31) ? 31 : 7 + 4 * phase;
            no_idle = (phase == 3);
            if (phase == 3)
                hold_request = 1'b1;
            for (n = 0; n < VOTES_PER_PASS; n++)
                send_vote(random_vote(window));
            no_idle = 1'b0;
        end
        drain();
        repeat (8) @(negedge aclk);

        if (tally.expected_outcomes.size() != 0) begin
            tally.mismatches++;
            $display("%0d votes never produced a result", tally.expected_outcomes.size());
        end
        $display("Ran %0d votes over %0d register writes: %0d accepted, %0d duplicate, %0d %s",
                 votes_sent, cfg_writes, tally.verdict_count[VERDICT_ACCEPTED],
                 tally.verdict_count[VERDICT_DUPLICATE],
                 tally.verdict_count[VERDICT_CONFLICTING], "conflicting");
        $display("%0d unknown voters; %0d results compared, %0d mismatches",
                 tally.verdict_count[VERDICT_UNKNOWN], tally.checked, tally.mismatches);
        if (tally.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
